### design/pwi_pkg.sv
// Package for the windowed-integral PID unit: widths, register codes and
// the structs passed between the front end, the back end and the top level.
// No dependencies.
package pwi_pkg;

  localparam int MAX_WINDOW = 64;

  localparam int POS_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LEN_W   = 7;
  localparam int DRIVE_W = 32;
  localparam int ERR_W   = POS_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int ENTRY_W = 8;
  localparam int IDX_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int ELEN_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SUM_W   = IDX_W + ENTRY_W;

  localparam int P_W   = (GAIN_W + 1) + ERR_W;
  localparam int I_W   = (GAIN_W + 1) + SUM_W;
  localparam int D_W   = (GAIN_W + 1) + DIFF_W;
  localparam int PID_W = (P_W > I_W) ? ((P_W > D_W) ? P_W : D_W) : ((I_W > D_W) ? I_W : D_W);
  localparam int ACC_W = PID_W + 2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_KD_GAIN    = 3'd2,
    REG_WINDOW_LEN = 3'd3
  } pwi_reg_e;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ENTRY_W-1:0] entry;
  } pwi_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LEN_W-1:0]  window_len;
    logic              recalc;
  } pwi_cfg_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } pwi_result_t;

endpackage

### design/pid_windowed_integral_unit.sv
// PID controller with a moving-window integral term.
// Each sample (target_pos_i, measured_pos_i) is pushed with push while full
// is low; one result (drive_o, saturated_o) per sample is offered while
// empty is low and taken with pop.
// The back end takes no new sample while one is in its window stage: the window
// RAM is read for the replaced entry as a sample is taken and written from that stage.
// With idle queues, empty goes low once an accepted sample has passed the input
// queue and the window, sum and product stages and is written into the result queue.
// Results wait in a 4-entry queue; while pop is held low the queue fills,
// the back end stops taking samples, then the 2-entry input queue fills
// and full rises. No result is dropped.
// Configuration writes go through cfg_valid_i/cfg_ready_o with a register
// index and data; cfg_ready_o is always high. Write only while idle.
// Writing window_len starts a rebuild of the window sum; samples wait in the
// input queue until every entry within the effective length has been read back.
// Reset clears the window (per-entry valid bits), the ring index, the sum,
// the previous error and all gain registers; window_len returns to 16.
// Depends on pwi_pkg, pwi_front, pwi_back and pwi_ram.
module pid_windowed_integral_unit
  import pwi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [POS_W-1:0]     target_pos_i,
  input  logic [POS_W-1:0]     measured_pos_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [DRIVE_W-1:0]   drive_o,
  output logic                 saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic              cfg_we;
  logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [LEN_W-1:0]  window_len_q;
  logic              recalc_q;
  pwi_cfg_t          cfg;
  logic              item_valid, item_pop;
  pwi_item_t         item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      window_len_q <= LEN_W'(16);
      recalc_q     <= 1'b0;
    end else begin
      recalc_q <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_KP_GAIN:    kp_q <= cfg_data_i[GAIN_W-1:0];
          REG_KI_GAIN:    ki_q <= cfg_data_i[GAIN_W-1:0];
          REG_KD_GAIN:    kd_q <= cfg_data_i[GAIN_W-1:0];
          REG_WINDOW_LEN: begin
            window_len_q <= cfg_data_i[LEN_W-1:0];
            recalc_q     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign cfg = '{kp: kp_q, ki: ki_q, kd: kd_q, window_len: window_len_q, recalc: recalc_q};

  pwi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .target_pos_i  (target_pos_i),
    .measured_pos_i(measured_pos_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  pwi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .empty       (empty),
    .pop         (pop),
    .drive_o     (drive_o),
    .saturated_o (saturated_o)
  );

endmodule

### design/pwi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/pwi_front.sv
// Front end: accepts position samples, forms error, difference and the
// clamped window entry, and queues them for the back end. Uses pwi_pkg.
module pwi_front
  import pwi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [POS_W-1:0] target_pos_i,
  input  logic [POS_W-1:0] measured_pos_i,
  output logic             item_valid_o,
  output pwi_item_t        item_o,
  input  logic             item_pop_i
);

  logic                     accept;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ENTRY_W-1:0] entry;
  logic signed [ERR_W-1:0]  last_err_q, last_err_d;
  pwi_item_t                fq_q [FQ_DEPTH];
  logic                     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]               cnt_q, cnt_d;

  assign full   = (cnt_q == 2'(FQ_DEPTH));
  assign accept = push && !full;

  always_comb begin
    err  = $signed({1'b0, target_pos_i}) - $signed({1'b0, measured_pos_i});
    diff = DIFF_W'(err) - DIFF_W'(last_err_q);
    if (err > ERR_W'(127)) begin
      entry = 8'sd127;
    end else if (err < -ERR_W'(128)) begin
      entry = -8'sd128;
    end else begin
      entry = err[ENTRY_W-1:0];
    end
  end

  always_comb begin
    last_err_d = accept ? err : last_err_q;
    wptr_d     = accept ? ~wptr_q : wptr_q;
    rptr_d     = item_pop_i ? ~rptr_q : rptr_q;
    cnt_d      = cnt_q + 2'(accept) - 2'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      last_err_q <= last_err_d;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_q[wptr_q] <= '{err: err, diff: diff, entry: entry};
    end
  end

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = fq_q[rptr_q];

endmodule

### design/pwi_back.sv
// Back end: ring window update through the window RAM, running sum, gain
// multiplies, saturation and the result queue. Uses pwi_pkg and pwi_ram.
module pwi_back
  import pwi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwi_cfg_t           cfg_i,
  input  logic               item_valid_i,
  input  pwi_item_t          item_i,
  output logic               item_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [DRIVE_W-1:0] drive_o,
  output logic               saturated_o
);

  logic [ELEN_W-1:0] len_x;
  logic [CNT_W-1:0]  len_eff;
  logic [CNT_W-1:0]  slot_c, slot_nx;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;

  logic              issue;
  logic              credit_ok;
  logic              sweep_busy;
  logic              sweep_q, sweep_d;
  logic              sweep_rd_q, sweep_rd_d;
  logic [CNT_W-1:0]  sweep_idx_q, sweep_idx_d;
  logic              sweep_issue;

  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              vld_q [MAX_WINDOW];
  logic              rd_vld_q;
  logic signed [ENTRY_W-1:0] old_entry;

  logic              s1_v_q;
  pwi_item_t         s1_item_q;
  logic [IDX_W-1:0]  s1_slot_q;

  logic signed [SUM_W-1:0] sum_q, sum_d, sum_upd;

  logic                     s2_v_q;
  logic signed [ERR_W-1:0]  s2_err_q;
  logic signed [DIFF_W-1:0] s2_diff_q;
  logic signed [SUM_W-1:0]  s2_sum_q;

  logic                  s3_v_q;
  logic signed [P_W-1:0] p_q;
  logic signed [I_W-1:0] i_q;
  logic signed [D_W-1:0] d_q;

  logic signed [ACC_W-1:0]      acc;
  logic [ACC_W-1-(DRIVE_W-1):0] acc_hi;
  pwi_result_t                  res;

  pwi_result_t        oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wptr_q, oq_rptr_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q;
  logic                oq_push, oq_pop;
  logic [OQ_CNT_W-1:0] in_flight;

  always_comb begin
    len_x = ELEN_W'(cfg_i.window_len);
    if (len_x == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_x > ELEN_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = len_x[CNT_W-1:0];
    end
    slot_c  = (CNT_W'(wr_idx_q) < len_eff) ? CNT_W'(wr_idx_q) : '0;
    slot_nx = slot_c + CNT_W'(1);
    if (slot_nx >= len_eff) begin
      slot_nx = '0;
    end
  end

  assign sweep_busy = sweep_q || sweep_rd_q;
  assign in_flight  = OQ_CNT_W'(s1_v_q) + OQ_CNT_W'(s2_v_q) + OQ_CNT_W'(s3_v_q);
  assign credit_ok  = (OQ_CNT_W'(oq_cnt_q + in_flight) < OQ_CNT_W'(OQ_DEPTH));
  assign issue      = item_valid_i && !s1_v_q && !sweep_busy && !cfg_i.recalc && credit_ok;
  assign item_pop_o = issue;

  assign sweep_issue = sweep_q && (sweep_idx_q < len_eff);

  always_comb begin
    sweep_d     = sweep_q;
    sweep_idx_d = sweep_idx_q;
    sweep_rd_d  = 1'b0;
    if (cfg_i.recalc) begin
      sweep_d     = 1'b1;
      sweep_idx_d = '0;
    end else if (sweep_issue) begin
      sweep_idx_d = sweep_idx_q + CNT_W'(1);
      sweep_rd_d  = 1'b1;
    end else begin
      sweep_d = 1'b0;
    end
  end

  assign ram_re    = issue || sweep_issue;
  assign ram_raddr = sweep_issue ? sweep_idx_q[IDX_W-1:0] : slot_c[IDX_W-1:0];
  assign wr_idx_d  = issue ? slot_nx[IDX_W-1:0] : wr_idx_q;

  pwi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (s1_v_q),
    .waddr_i(s1_slot_q),
    .wdata_i(s1_item_q.entry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign old_entry = rd_vld_q ? $signed(ram_rdata) : '0;

  always_comb begin
    sum_upd = sum_q + SUM_W'(s1_item_q.entry) - SUM_W'(old_entry);
    sum_d   = sum_q;
    if (cfg_i.recalc) begin
      sum_d = '0;
    end else if (sweep_rd_q) begin
      sum_d = sum_q + SUM_W'(old_entry);
    end else if (s1_v_q) begin
      sum_d = sum_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      sweep_q     <= 1'b0;
      sweep_rd_q  <= 1'b0;
      sweep_idx_q <= '0;
      sum_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      wr_idx_q    <= wr_idx_d;
      sweep_q     <= sweep_d;
      sweep_rd_q  <= sweep_rd_d;
      sweep_idx_q <= sweep_idx_d;
      sum_q       <= sum_d;
      s1_v_q      <= issue;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (s1_v_q) begin
        vld_q[s1_slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_item_q <= item_i;
      s1_slot_q <= slot_c[IDX_W-1:0];
    end
    if (s1_v_q) begin
      s2_err_q  <= s1_item_q.err;
      s2_diff_q <= s1_item_q.diff;
      s2_sum_q  <= sum_upd;
    end
    if (s2_v_q) begin
      p_q <= P_W'($signed({1'b0, cfg_i.kp}) * s2_err_q);
      i_q <= I_W'($signed({1'b0, cfg_i.ki}) * s2_sum_q);
      d_q <= D_W'($signed({1'b0, cfg_i.kd}) * s2_diff_q);
    end
  end

  always_comb begin
    acc    = ACC_W'(p_q) + ACC_W'(i_q) + ACC_W'(d_q);
    acc_hi = acc[ACC_W-1:DRIVE_W-1];
    res.sat = !((acc_hi == '0) || (acc_hi == '1));
    if (res.sat) begin
      res.drive = acc[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      res.drive = acc[DRIVE_W-1:0];
    end
  end

  assign oq_push = s3_v_q;
  assign oq_pop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= '0;
      oq_rptr_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (oq_push) begin
        oq_wptr_q <= oq_wptr_q + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rptr_q <= oq_rptr_q + OQ_PTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wptr_q] <= res;
    end
  end

  assign empty       = (oq_cnt_q == '0);
  assign drive_o     = oq_q[oq_rptr_q].drive;
  assign saturated_o = oq_q[oq_rptr_q].sat;

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !sweep_busy)
    else $error("window write overlaps sum rebuild");

  a_window_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |=> !s1_v_q)
    else $error("window stage took items in consecutive cycles");

  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> (oq_cnt_q < OQ_CNT_W'(OQ_DEPTH)) || oq_pop)
    else $error("result queue overflow");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oq_cnt_q + in_flight) <= OQ_CNT_W'(OQ_DEPTH))
    else $error("results in flight exceed queue space");

endmodule
